FILE: hdl/alle_pkg.sv
`default_nettype none
package alle_pkg;

    localparam int CAPACITY_DEF   = 255;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int NODE_DEPTH     = 256;
    localparam int CELL_W         = 8;
    localparam logic [63:0] POISON = 64'hDEAD;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_PUSH_FRONT = 3'd0;
    localparam t_opcode OP_PUSH_BACK  = 3'd1;
    localparam t_opcode OP_POP_FRONT  = 3'd2;
    localparam t_opcode OP_POP_BACK   = 3'd3;
    localparam t_opcode OP_INSERT     = 3'd4;
    localparam t_opcode OP_REMOVE     = 3'd5;
    localparam t_opcode OP_READ       = 3'd6;
    localparam t_opcode OP_LOOKUP     = 3'd7;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_EMPTY = 3'd1;
    localparam t_status ST_FULL  = 3'd2;
    localparam t_status ST_NULL  = 3'd3;
    localparam t_status ST_POS   = 3'd4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [7:0]         cell_req;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         result_cell;
        logic signed [31:0] cell_value;
        logic [7:0]         next_link;
        logic [7:0]         prev_link;
        logic [7:0]         used_count;
        logic [7:0]         front_cell;
        logic [7:0]         back_cell;
        logic               is_linear;
    } t_out_word;

endpackage
`default_nettype wire

FILE: hdl/array_linked_list_engine_unit.sv
`default_nettype none
// Doubly linked list engine over a 256-entry node memory (value, next, prev).
// Input channel: i_valid / o_stall carry one command word (opcode, cell,
// value, position). Output channel: o_valid / i_stall carry one result word
// per command with status, cell, read contents, count and end pointers.
// Path from the accepting edge to S_OUT, which loads the output register:
// direct for commands without memory work, through S_W1 for read and pop
// front, through S_W1 and S_W2 for other list edits; S_OUT returns to S_IDLE
// before the next word. A walking lookup steps through S_WALK, one next link
// per cycle out of the next-link memory. One command is in flight at a time.
// After reset a clearing pass loads each of the 256 cells (poison value,
// null next link, free chain in prev links); o_stall is high meanwhile.
// The result sits in an output register; a stalled result holds, and the
// engine finishes the next command and waits until the register frees.
module array_linked_list_engine_unit #(
    parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire alle_pkg::t_in_word i_in,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output alle_pkg::t_out_word     o_out
);
    import alle_pkg::*;

    logic      seq_valid, out_free;
    t_out_word seq_out;

    alle_seq #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in(i_in),
        .o_stall(o_stall), .o_valid(seq_valid), .i_out_free(out_free),
        .o_out(seq_out)
    );

    assign out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_free) begin
            o_valid <= seq_valid;
        end
        if (out_free && seq_valid) begin
            o_out <= seq_out;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/alle_ram.sv
`default_nettype none
module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/alle_seq.sv
`default_nettype none
module alle_seq #(
    parameter int CAPACITY   = 255,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire alle_pkg::t_in_word i_in,
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_out_free,
    output alle_pkg::t_out_word     o_out
);
    import alle_pkg::*;

    localparam int CELLS = (CAPACITY < 255) ? CAPACITY : 255;
    localparam logic [8:0] CELLS_W = 9'(CELLS);
    localparam logic [DATA_WIDTH-1:0] POISON_W = POISON[DATA_WIDTH-1:0];

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_W1    = 6'b000100,
        S_W2    = 6'b001000,
        S_WALK  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef enum logic [3:0] {
        K_NONE, K_PUSHF, K_PUSHB, K_POPF, K_POPB, K_INS, K_REM, K_READ
    } t_kind;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [7:0] r_req, n_req, r_cell, n_cell, r_aux, n_aux, r_cnt, n_cnt;
    logic [7:0] r_front, n_front, r_back, n_back, r_free, n_free, r_count, n_count;
    logic       r_linear, n_linear;
    logic [7:0] r_clr, n_clr;
    t_status    r_st, n_st;
    logic [7:0] r_rcell, n_rcell, r_rnext, n_rnext, r_rprev, n_rprev;
    logic [31:0] r_rval, n_rval;

    logic                  val_we, next_we, prev_we;
    logic [7:0]            val_wa, next_wa, prev_wa, val_ra, next_ra, prev_ra;
    logic [DATA_WIDTH-1:0] val_wd, val_rd;
    logic [7:0]            next_wd, prev_wd, next_rd, prev_rd;
    logic signed [63:0]    rd_ext, in_ext;
    logic                  req_ok;

    alle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODE_DEPTH)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_wa), .i_wdata(val_wd),
        .i_raddr(val_ra), .o_rdata(val_rd)
    );
    alle_ram #(.WIDTH(CELL_W), .DEPTH(NODE_DEPTH)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(next_ra), .o_rdata(next_rd)
    );
    alle_ram #(.WIDTH(CELL_W), .DEPTH(NODE_DEPTH)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(prev_ra), .o_rdata(prev_rd)
    );

    assign rd_ext = 64'(signed'(val_rd));
    assign in_ext = 64'(i_in.value);
    assign req_ok = ({1'b0, i_in.cell_req} <= CELLS_W);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    always_comb begin
        o_out.status      = r_st;
        o_out.result_cell = r_rcell;
        o_out.cell_value  = signed'(r_rval);
        o_out.next_link   = r_rnext;
        o_out.prev_link   = r_rprev;
        o_out.used_count  = r_count;
        o_out.front_cell  = r_front;
        o_out.back_cell   = r_back;
        o_out.is_linear   = r_linear;
    end

    always_comb begin
        n_state = r_state; n_kind = r_kind; n_val = r_val; n_req = r_req;
        n_cell = r_cell; n_aux = r_aux; n_cnt = r_cnt; n_front = r_front;
        n_back = r_back; n_free = r_free; n_count = r_count; n_linear = r_linear;
        n_clr = r_clr; n_st = r_st; n_rcell = r_rcell; n_rnext = r_rnext;
        n_rprev = r_rprev; n_rval = r_rval;
        val_we = 1'b0; next_we = 1'b0; prev_we = 1'b0;
        val_wa = 8'd0; next_wa = 8'd0; prev_wa = 8'd0;
        val_wd = POISON_W; next_wd = 8'd0; prev_wd = 8'd0;
        val_ra = r_req; next_ra = r_req; prev_ra = r_req;

        case (r_state)
            S_CLEAR: begin
                // sweep every cell to its reset contents
                val_we = 1'b1; next_we = 1'b1; prev_we = 1'b1;
                val_wa = r_clr; next_wa = r_clr; prev_wa = r_clr;
                if (r_clr != 8'd0 && {1'b0, r_clr} < CELLS_W) begin
                    prev_wd = 8'(r_clr + 8'd1);
                end
                n_clr = 8'(r_clr + 8'd1);
                if (r_clr == 8'd255) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_val   = in_ext[DATA_WIDTH-1:0];
                    n_req   = i_in.cell_req;
                    n_cell  = i_in.cell_req;
                    n_st    = ST_OK;
                    n_rcell = i_in.cell_req;
                    n_rval  = 32'd0; n_rnext = 8'd0; n_rprev = 8'd0;
                    n_kind  = K_NONE;
                    n_state = S_W1;
                    prev_ra = r_free;
                    case (i_in.opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_cell = r_free;
                            if (r_free == 8'd0) begin
                                n_st = ST_FULL; n_rcell = 8'd0;
                            end else begin
                                n_kind = (i_in.opcode == OP_PUSH_FRONT) ? K_PUSHF : K_PUSHB;
                            end
                        end
                        OP_POP_FRONT: begin
                            n_cell = r_front; prev_ra = r_front; n_rcell = r_front;
                            if (r_front == 8'd0) n_st = ST_EMPTY;
                            else n_kind = K_POPF;
                        end
                        OP_POP_BACK: begin
                            n_cell = r_back; next_ra = r_back; n_rcell = r_back;
                            if (r_back == 8'd0) n_st = ST_EMPTY;
                            else n_kind = K_POPB;
                        end
                        OP_INSERT: begin
                            next_ra = i_in.cell_req;
                            n_cell  = r_free;
                            if (!req_ok || i_in.cell_req == 8'd0) begin
                                n_st = ST_NULL;
                            end else if (r_free == 8'd0) begin
                                n_st = ST_FULL; n_rcell = 8'd0;
                            end else if (i_in.cell_req == r_front) begin
                                n_kind = K_PUSHF;
                            end else begin
                                n_kind = K_INS;
                            end
                        end
                        OP_REMOVE: begin
                            prev_ra = i_in.cell_req; next_ra = i_in.cell_req;
                            if (!req_ok || i_in.cell_req == 8'd0) n_st = ST_NULL;
                            else if (i_in.cell_req == r_front) n_kind = K_POPF;
                            else if (i_in.cell_req == r_back) n_kind = K_POPB;
                            else n_kind = K_REM;
                        end
                        OP_READ: begin
                            prev_ra = i_in.cell_req; next_ra = i_in.cell_req;
                            val_ra  = i_in.cell_req;
                            if (!req_ok) n_st = ST_NULL;
                            else n_kind = K_READ;
                        end
                        default: begin
                            next_ra = r_back;
                            n_cnt   = i_in.position;
                            if (r_linear) begin
                                if ({1'b0, i_in.position} + 9'd1 > CELLS_W) begin
                                    n_st = ST_POS; n_rcell = 8'd0;
                                end else begin
                                    n_rcell = 8'(i_in.position + 8'd1);
                                end
                            end else if (i_in.position == 8'd0) begin
                                n_rcell = r_back;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                    endcase
                    if (n_kind == K_NONE && n_state == S_W1) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_W1: begin
                n_rcell = r_cell;
                n_state = S_W2;
                case (r_kind)
                    K_PUSHF: begin
                        val_we = 1'b1; val_wa = r_cell; val_wd = r_val;
                        prev_we = 1'b1; prev_wa = r_cell; prev_wd = r_front;
                        next_we = 1'b1; next_wa = r_cell;
                        n_free = prev_rd;
                    end
                    K_PUSHB: begin
                        val_we = 1'b1; val_wa = r_cell; val_wd = r_val;
                        next_we = 1'b1; next_wa = r_cell; next_wd = r_back;
                        prev_we = 1'b1; prev_wa = r_cell;
                        n_free = prev_rd; n_linear = 1'b0;
                    end
                    K_POPF: begin
                        next_we = 1'b1; next_wa = prev_rd;
                        prev_we = 1'b1; prev_wa = r_cell; prev_wd = r_free;
                        val_we = 1'b1; val_wa = r_cell;
                        n_free = r_cell; n_front = prev_rd;
                        if (prev_rd == 8'd0) n_back = 8'd0;
                        n_count = 8'(r_count - 8'd1);
                        n_state = S_OUT;
                    end
                    K_POPB: begin
                        prev_we = 1'b1; prev_wa = r_cell; prev_wd = r_free;
                        val_we = 1'b1; val_wa = r_cell;
                        n_free = r_cell; n_linear = 1'b0; n_aux = next_rd;
                    end
                    K_INS: begin
                        val_we = 1'b1; val_wa = r_cell; val_wd = r_val;
                        prev_we = 1'b1; prev_wa = r_cell; prev_wd = r_req;
                        next_we = 1'b1; next_wa = r_cell; next_wd = next_rd;
                        n_free = prev_rd; n_aux = next_rd; n_linear = 1'b0;
                    end
                    K_REM: begin
                        // unlink: neighbors point past the cell
                        next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
                        prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
                        n_linear = 1'b0;
                    end
                    default: begin
                        n_rval  = rd_ext[31:0];
                        n_rnext = next_rd;
                        n_rprev = prev_rd;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_W2: begin
                n_state = S_OUT;
                case (r_kind)
                    K_PUSHF: begin
                        next_we = (r_front != 8'd0); next_wa = r_front; next_wd = r_cell;
                        n_front = r_cell;
                        if (r_back == 8'd0) n_back = r_cell;
                        n_count = 8'(r_count + 8'd1);
                    end
                    K_PUSHB: begin
                        prev_we = (r_back != 8'd0); prev_wa = r_back; prev_wd = r_cell;
                        n_back = r_cell;
                        if (r_front == 8'd0) n_front = r_cell;
                        n_count = 8'(r_count + 8'd1);
                    end
                    K_POPB: begin
                        prev_we = 1'b1; prev_wa = r_aux;
                        n_back = r_aux;
                        if (r_aux == 8'd0) n_front = 8'd0;
                        n_count = 8'(r_count - 8'd1);
                    end
                    K_INS: begin
                        prev_we = 1'b1; prev_wa = r_aux; prev_wd = r_cell;
                        next_we = 1'b1; next_wa = r_req; next_wd = r_cell;
                        n_count = 8'(r_count + 8'd1);
                    end
                    K_REM: begin
                        prev_we = 1'b1; prev_wa = r_req; prev_wd = r_free;
                        val_we = 1'b1; val_wa = r_req;
                        n_free = r_req;
                        n_count = 8'(r_count - 8'd1);
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                // follow one next link per cycle, addressed straight from read data
                next_ra = next_rd;
                n_cnt   = 8'(r_cnt - 8'd1);
                if (next_rd == 8'd0) begin
                    n_st = ST_POS; n_rcell = 8'd0; n_state = S_OUT;
                end else if (r_cnt == 8'd1) begin
                    n_rcell = next_rd; n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= 8'd0;
            r_front  <= 8'd0;
            r_back   <= 8'd0;
            r_free   <= (CELLS >= 1) ? 8'd1 : 8'd0;
            r_count  <= 8'd0;
            r_linear <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_front  <= n_front;
            r_back   <= n_back;
            r_free   <= n_free;
            r_count  <= n_count;
            r_linear <= n_linear;
        end
        r_kind <= n_kind; r_val <= n_val; r_req <= n_req; r_cell <= n_cell;
        r_aux <= n_aux; r_cnt <= n_cnt; r_st <= n_st; r_rcell <= n_rcell;
        r_rnext <= n_rnext; r_rprev <= n_rprev; r_rval <= n_rval;
    end
endmodule
`default_nettype wire
